// ===== hdl/tcpq_pkg.sv =====
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam logic [7:0] THRESHOLD_RESET = 8'd60;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SERVE   = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_SERVED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] client_id;
        logic [7:0]  client_age;
    } t_in_item;

    typedef struct packed {
        logic [31:0] served_id;
        logic [1:0]  status;
        logic        served_priority;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // request taken this cycle
        logic deliver;  // load serve result from memory read data
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic serve_hit;  // pending request is a serve with a nonempty queue
    } t_dp_status;

endpackage

// ===== hdl/tcpq_fifo.sv =====
`timescale 1ns / 1ps

module tcpq_fifo #(
    parameter int DEPTH = tcpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [31:0] i_wdata,
    input  logic        i_pop,
    output logic [31:0] o_rdata,
    output logic        o_empty,
    output logic        o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [31:0]   r_mem [DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [31:0]   r_rdata;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == DEPTH_C);
    assign o_rdata = r_rdata;

    // tail = (head + count) mod DEPTH, count below DEPTH when pushing
    always_comb begin
        tail_sum = {1'b0, r_head} + (AW + 1)'(r_count);
        if (tail_sum >= DEPTH_W) begin
            tail_sum = tail_sum - DEPTH_W;
        end
        tail = tail_sum[AW-1:0];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_push) begin
            n_count = r_count + 1'b1;
        end else if (i_pop) begin
            n_count = r_count - 1'b1;
            n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count beyond depth");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not reduce count");

endmodule

// ===== hdl/tcpq_datapath.sv =====
`timescale 1ns / 1ps

module tcpq_datapath #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcpq_pkg::t_ctrl      i_ctrl,
    output tcpq_pkg::t_dp_status o_status,
    input  tcpq_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcpq_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0]          r_thresh;
    logic                r_out_valid;
    logic                n_out_valid;
    tcpq_pkg::t_out_item r_out;
    tcpq_pkg::t_out_item n_out;
    logic                r_from_hi;

    logic        age_hi;
    logic        is_serve;
    logic        hi_push, lo_push, hi_pop, lo_pop;
    logic        hi_empty, hi_full, lo_empty, lo_full;
    logic [31:0] hi_rdata, lo_rdata;
    logic        drop;
    logic        out_free;

    assign age_hi   = (i_in_data.client_age >= r_thresh);
    assign is_serve = (i_in_data.cmd == tcpq_pkg::CMD_SERVE);
    assign drop     = age_hi ? hi_full : lo_full;

    assign hi_push = i_ctrl.accept && !is_serve && age_hi && !hi_full;
    assign lo_push = i_ctrl.accept && !is_serve && !age_hi && !lo_full;
    assign hi_pop  = i_ctrl.accept && is_serve && !hi_empty;
    assign lo_pop  = i_ctrl.accept && is_serve && hi_empty && !lo_empty;

    assign out_free           = !r_out_valid || i_out_ready;
    assign o_status.out_free  = out_free;
    assign o_status.serve_hit = is_serve && !(hi_empty && lo_empty);

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tcpq_fifo #(.DEPTH(QUEUE_DEPTH)) u_hi_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (hi_push),
        .i_wdata (i_in_data.client_id),
        .i_pop   (hi_pop),
        .o_rdata (hi_rdata),
        .o_empty (hi_empty),
        .o_full  (hi_full)
    );

    tcpq_fifo #(.DEPTH(QUEUE_DEPTH)) u_lo_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lo_push),
        .i_wdata (i_in_data.client_id),
        .i_pop   (lo_pop),
        .o_rdata (lo_rdata),
        .o_empty (lo_empty),
        .o_full  (lo_full)
    );

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_ctrl.deliver) begin
            n_out.served_id       = r_from_hi ? hi_rdata : lo_rdata;
            n_out.status          = tcpq_pkg::ST_SERVED;
            n_out.served_priority = r_from_hi;
            n_out_valid           = 1'b1;
        end else if (i_ctrl.accept && !o_status.serve_hit) begin
            // enqueue or serve on empty: result known at once
            n_out.served_id       = '0;
            n_out.served_priority = 1'b0;
            if (is_serve) begin
                n_out.status = tcpq_pkg::ST_EMPTY;
            end else begin
                n_out.status = drop ? tcpq_pkg::ST_DROPPED : tcpq_pkg::ST_ENQUEUED;
            end
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_thresh    <= tcpq_pkg::THRESHOLD_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_ctrl.accept) begin
            r_from_hi <= hi_pop;
        end
    end

endmodule

// ===== hdl/tcpq_ctrl.sv =====
`timescale 1ns / 1ps

module tcpq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcpq_pkg::t_dp_status i_status,
    output tcpq_pkg::t_ctrl      o_ctrl
);

    tcpq_pkg::t_state r_state;
    tcpq_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcpq_pkg::S_IDLE: begin
                if (i_in_valid && i_status.out_free && i_status.serve_hit) begin
                    n_state = tcpq_pkg::S_READ;
                end
            end
            tcpq_pkg::S_READ: begin
                if (i_status.out_free) begin
                    n_state = tcpq_pkg::S_IDLE;
                end
            end
            default: n_state = tcpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_ctrl.accept  = 1'b0;
        o_ctrl.deliver = 1'b0;
        unique case (r_state)
            tcpq_pkg::S_IDLE: begin
                o_in_ready    = i_status.out_free;
                o_ctrl.accept = i_in_valid && i_status.out_free;
            end
            tcpq_pkg::S_READ: begin
                o_ctrl.deliver = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_deliver_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.accept && o_ctrl.deliver))
        else $error("accept and deliver in same cycle");

    a_hit_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.accept && i_status.serve_hit) |=> (r_state == tcpq_pkg::S_READ))
        else $error("serve hit did not start read");

    a_deliver_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.deliver |=> (r_state == tcpq_pkg::S_IDLE))
        else $error("deliver did not return to idle");

endmodule

// ===== hdl/two_class_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Two-class strict-priority FIFO of 32-bit client identifiers. An enqueue
// request (cmd 0) goes to the high queue when client_age is at or above the
// threshold register (reset 60), else to the low queue; a full target queue
// drops it with status 3. A serve request (cmd 1) pops the high queue first,
// then the low queue, or returns status 2 when both are empty. Each request
// yields exactly one result. Unlike enqueues and empty serves, a successful
// serve first reads the queue memory through its registered read port and
// holds the input off during its read cycle. A new request is taken in the
// cycle the previous result leaves the output register; while a result is
// stalled, the input waits. The user must write the threshold through the
// cfg channel only while the block is idle; the block does not enforce it.
module two_class_priority_queue_unit #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcpq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcpq_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    tcpq_pkg::t_ctrl      ctrl;
    tcpq_pkg::t_dp_status dp_status;

    tcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_ctrl     (ctrl)
    );

    tcpq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
